>>> rtl/akvt_pkg.sv
// shared types and constants for the aging key/value table
package akvt_pkg;

   localparam int TABLE_DEPTH   = 16;
   localparam int KEY_BITS      = 64;
   localparam int VALUE_BITS    = 64;
   localparam int IDX_BITS      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   localparam int TIME_BITS     = 32;
   localparam int TICK_BITS     = 16;
   localparam int COUNT_BITS    = 5;
   localparam int CMD_BITS      = 2;
   localparam int STATUS_BITS   = 2;
   localparam int KEY_FIELD     = 64;
   localparam int VALUE_FIELD   = 64;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   localparam logic [COUNT_BITS-1:0]   COUNT_MAX        = '1;
   localparam logic [TICK_BITS-1:0]    EXPIRE_RESET     = TICK_BITS'(10);
   localparam logic [CSR_IDX_BITS-1:0] CSR_EXPIRE_TICKS = '0;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_DUPLICATE = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [CMD_BITS-1:0]    command;
      logic [KEY_FIELD-1:0]   key;
      logic [VALUE_FIELD-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [VALUE_FIELD-1:0] read_value;
      logic [COUNT_BITS-1:0]  removed_count;
   } rsp_word_type;

endpackage

>>> rtl/aging_key_value_table_unit.sv
// aging key/value table: entry scan sequencer with expiry sweep
//
//  channel  | ports                              | direction | transfer
//  ---------+------------------------------------+-----------+---------------------------
//  req      | req_valid, req_stall, req_data     | in        | valid & !stall
//  rsp      | rsp_valid, rsp_stall, rsp_data     | out       | valid & !stall
//  csr      | csr_psel/penable/pwrite/paddr/...  | in        | psel & penable & pwrite
//
// every word is taken in IDLE, then SCAN walks the table entries in order, each through the
// single key compare / expiry compare unit, and FINISH commits and loads the result register.
// req_stall is high from the cycle after a word is taken until its result is loaded.
// the result register holds while rsp_stall is high; a new word is still taken meanwhile.
// reset is synchronous: the table is empty, time is zero and expire_ticks is 10.
module aging_key_value_table_unit
   import akvt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_word_type             req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_word_type             rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      FINISH
   } state_type;

   state_type                state_ff;
   logic [TABLE_DEPTH-1:0]   valid_ff;
   logic [KEY_BITS-1:0]      entry_key_ff    [TABLE_DEPTH];
   logic [VALUE_BITS-1:0]    entry_value_ff  [TABLE_DEPTH];
   logic [TIME_BITS-1:0]     entry_expiry_ff [TABLE_DEPTH];

   logic [TIME_BITS-1:0]     time_ff;
   logic [TICK_BITS-1:0]     expire_ticks_ff;

   cmd_type                  cmd_ff;
   logic [KEY_BITS-1:0]      key_ff;
   logic [VALUE_BITS-1:0]    value_ff;
   logic [IDX_BITS-1:0]      scan_ff;
   logic                     hit_ff;
   logic [IDX_BITS-1:0]      hit_idx_ff;
   logic [VALUE_BITS-1:0]    hit_value_ff;
   logic                     free_ff;
   logic [IDX_BITS-1:0]      free_idx_ff;
   logic [COUNT_BITS-1:0]    count_ff;

   logic                     rsp_valid_ff;
   rsp_word_type             rsp_data_ff;
   rsp_word_type             rsp_in;

   logic                     key_hit;
   logic                     slot_free;
   logic                     expired;
   logic                     scan_last;
   logic                     out_open;
   logic                     csr_write;
   logic                     commit_insert;
   logic [TIME_BITS:0]       expiry_sum;
   logic [TIME_BITS-1:0]     expiry_in;
   logic [TIME_BITS-1:0]     time_in;

   // one entry per cycle through the shared compare unit
   assign key_hit   = valid_ff[scan_ff] && (entry_key_ff[scan_ff] == key_ff);
   assign slot_free = !valid_ff[scan_ff];
   assign expired   = valid_ff[scan_ff] && (entry_expiry_ff[scan_ff] < time_ff);
   assign scan_last = (scan_ff == IDX_BITS'(TABLE_DEPTH - 1));
   assign out_open  = !rsp_valid_ff || !rsp_stall;

   assign expiry_sum = {1'b0, time_ff} + (TIME_BITS + 1)'(expire_ticks_ff);
   assign expiry_in  = expiry_sum[TIME_BITS] ? '1 : expiry_sum[TIME_BITS-1:0];
   assign time_in    = (time_ff == '1) ? time_ff : time_ff + 1'b1;

   assign csr_write = csr_psel && csr_penable && csr_pwrite &&
                      (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_EXPIRE_TICKS);

   assign commit_insert = (state_ff == FINISH) && out_open && (cmd_ff == CMD_INSERT) &&
                          !hit_ff && free_ff;

   always_comb begin
      rsp_in               = '0;
      rsp_in.removed_count = count_ff;
      unique case (cmd_ff)
         CMD_INSERT: begin
            priority if (hit_ff) begin
               rsp_in.status = STAT_DUPLICATE;
            end else if (!free_ff) begin
               rsp_in.status = STAT_FULL;
            end else begin
               rsp_in.status = STAT_OK;
            end
         end
         CMD_GET: begin
            rsp_in.status     = hit_ff ? STAT_OK : STAT_NOT_FOUND;
            rsp_in.read_value = hit_ff ? VALUE_FIELD'(hit_value_ff) : '0;
         end
         CMD_REMOVE: begin
            rsp_in.status = hit_ff ? STAT_OK : STAT_NOT_FOUND;
         end
         CMD_TICK: begin
            rsp_in.status = STAT_OK;
         end
         default: begin
            rsp_in.status = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= IDLE;
         valid_ff        <= '0;
         time_ff         <= '0;
         expire_ticks_ff <= EXPIRE_RESET;
         rsp_valid_ff    <= 1'b0;
         cmd_ff          <= CMD_INSERT;
      end else begin
         if (csr_write) begin
            expire_ticks_ff <= csr_pwdata[TICK_BITS-1:0];
         end
         // result register loads when the scan is done and the output is free
         if ((state_ff == FINISH) && out_open) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  cmd_ff       <= cmd_type'(req_data.command);
                  key_ff       <= req_data.key[KEY_BITS-1:0];
                  value_ff     <= req_data.value[VALUE_BITS-1:0];
                  scan_ff      <= '0;
                  hit_ff       <= 1'b0;
                  hit_idx_ff   <= '0;
                  hit_value_ff <= '0;
                  free_ff      <= 1'b0;
                  free_idx_ff  <= '0;
                  count_ff     <= '0;
                  // time moves before the sweep compares against it
                  if (cmd_type'(req_data.command) == CMD_TICK) begin
                     time_ff <= time_in;
                  end
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (cmd_ff == CMD_TICK) begin
                  if (expired) begin
                     valid_ff[scan_ff] <= 1'b0;
                     if (count_ff != COUNT_MAX) begin
                        count_ff <= count_ff + 1'b1;
                     end
                  end
               end else begin
                  if (key_hit && !hit_ff) begin
                     hit_ff       <= 1'b1;
                     hit_idx_ff   <= scan_ff;
                     hit_value_ff <= entry_value_ff[scan_ff];
                  end
                  // lowest free slot wins
                  if (slot_free && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= scan_ff;
                  end
               end
               if (scan_last) begin
                  state_ff <= FINISH;
               end else begin
                  scan_ff <= scan_ff + 1'b1;
               end
            end
            FINISH: begin
               if (out_open) begin
                  rsp_data_ff  <= rsp_in;
                  if (commit_insert) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                  end
                  if ((cmd_ff == CMD_REMOVE) && hit_ff) begin
                     valid_ff[hit_idx_ff] <= 1'b0;
                  end
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   // entry payload, meaningful only where the valid bit is set
   always_ff @(posedge clock) begin
      if (commit_insert) begin
         entry_key_ff[free_idx_ff]    <= key_ff;
         entry_value_ff[free_idx_ff]  <= value_ff;
         entry_expiry_ff[free_idx_ff] <= expiry_in;
      end
   end

   assign req_stall  = (state_ff != IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_EXPIRE_TICKS) ?
                       CSR_DATA_BITS'(expire_ticks_ff) : '0;

endmodule

>>> rtl/akvt_checker.sv
// port-level checks for the aging key/value table, bound to the top level
module akvt_checker
   import akvt_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input rsp_word_type             rsp_data
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // a taken word keeps the block busy the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took a word and was not busy after it");

   // a new result only comes out of a busy block
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared with no word in work");

   // a non-ok result reports no removals: only a tick counts them, and a tick always reports ok
   a_count_only_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STAT_OK) |-> (rsp_data.removed_count == '0))
      else $error("removal count on a non-ok result");

   // failed commands return no value
   a_no_value_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == STAT_NOT_FOUND) ||
                    (rsp_data.status == STAT_DUPLICATE) ||
                    (rsp_data.status == STAT_FULL))
      |-> (rsp_data.read_value == '0))
      else $error("value returned on a failed command");

endmodule

bind aging_key_value_table_unit akvt_checker u_akvt_checker (.*);
